### rtl/lzrts_pkg.sv
// Package for the LZ reference token serializer.
// Holds the opcodes, register indexes, queue command type and sizing constants.
// No dependencies.
`timescale 1ns / 1ps
package lzrts_pkg;

    localparam int PosBits   = 32;
    localparam int FieldBits = 32;
    localparam int WidthBits = 3;
    localparam int StepBits  = 4;
    localparam int QueueDepth = 4;
    localparam int QueuePtrBits = $clog2(QueueDepth);
    localparam int TdataBits = 136;

    localparam logic [WidthBits-1:0] MaxWidth = 3'd4;
    localparam logic [7:0] Marker = 8'h01;
    localparam logic [StepBits-1:0] HeaderLastStep = 4'd8;

    localparam logic [1:0] OP_TEXT  = 2'd0;
    localparam logic [1:0] OP_REF   = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    localparam logic REG_REF_BYTES = 1'b0;
    localparam logic REG_LEN_BYTES = 1'b1;

    typedef enum logic [1:0] {
        CMD_TEXT,
        CMD_HEADER,
        CMD_REF
    } cmd_kind_t;

    // One queued command: a text byte, a header (total length in val_a)
    // or a reference (source in val_a, length in val_b).
    typedef struct packed {
        cmd_kind_t            kind;
        logic [7:0]           text_byte;
        logic [FieldBits-1:0] val_a;
        logic [FieldBits-1:0] val_b;
    } cmd_t;

endpackage

### rtl/lz_reference_token_serializer_core.sv
// LZ reference token serializer, top level with width registers.
// Accepted items pass through the queue, then the registered output stage.
// Output: one byte per cycle while m_tready is high and the queue holds data;
// a text item gives 1 byte, a reference 1+ref+len, a start 9; a 4-entry queue
// lets input be taken every cycle while it has room.
// Async active-low reset clears positions, queue and output; widths reset to 4.
`timescale 1ns / 1ps
module lz_reference_token_serializer_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // text_byte, ref_source, ref_length, ref_target, total_length
    input  logic [lzrts_pkg::TdataBits-1:0] s_tdata,
    // opcode
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_byte
    output logic [7:0]                      m_tdata,
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [lzrts_pkg::WidthBits-1:0] cfg_data
);
    import lzrts_pkg::*;

    logic [WidthBits-1:0] ref_bytes_reg;
    logic [WidthBits-1:0] ref_bytes_next;
    logic [WidthBits-1:0] len_bytes_reg;
    logic [WidthBits-1:0] len_bytes_next;
    logic [WidthBits-1:0] cfg_clamped;
    logic                 push;
    logic                 pop;
    logic                 empty;
    logic                 full;
    cmd_t                 push_cmd;
    cmd_t                 head;

    // hold widths above the maximum at the maximum
    assign cfg_clamped = (cfg_data > MaxWidth) ? MaxWidth : cfg_data;

    always_comb
    begin
        ref_bytes_next = ref_bytes_reg;
        len_bytes_next = len_bytes_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_REF_BYTES: ref_bytes_next = cfg_clamped;
                REG_LEN_BYTES: len_bytes_next = cfg_clamped;
                default:       ref_bytes_next = ref_bytes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_bytes_reg <= MaxWidth;
            len_bytes_reg <= MaxWidth;
        end
        else
        begin
            ref_bytes_reg <= ref_bytes_next;
            len_bytes_reg <= len_bytes_next;
        end
    end

    lzrts_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .opcode       (s_tuser),
        .text_byte    (s_tdata[7:0]),
        .ref_source   (s_tdata[39:8]),
        .ref_length   (s_tdata[71:40]),
        .ref_target   (s_tdata[103:72]),
        .total_length (s_tdata[135:104]),
        .ref_bytes    (ref_bytes_reg),
        .len_bytes    (len_bytes_reg),
        .queue_full   (full),
        .push         (push),
        .cmd          (push_cmd)
    );

    lzrts_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    lzrts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .ref_bytes (ref_bytes_reg),
        .len_bytes (len_bytes_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

### rtl/lzrts_front.sv
// Front end: accepts input items, tracks text and resume positions,
// and pushes byte, header and reference commands into the queue. Uses lzrts_pkg.
`timescale 1ns / 1ps
module lzrts_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      opcode,
    input  logic [7:0]                      text_byte,
    input  logic [lzrts_pkg::FieldBits-1:0] ref_source,
    input  logic [lzrts_pkg::FieldBits-1:0] ref_length,
    input  logic [lzrts_pkg::FieldBits-1:0] ref_target,
    input  logic [lzrts_pkg::FieldBits-1:0] total_length,
    input  logic [lzrts_pkg::WidthBits-1:0] ref_bytes,
    input  logic [lzrts_pkg::WidthBits-1:0] len_bytes,
    input  logic                            queue_full,
    output logic                            push,
    output lzrts_pkg::cmd_t                 cmd
);
    import lzrts_pkg::*;

    logic [PosBits-1:0] text_pos_reg;
    logic [PosBits-1:0] text_pos_next;
    logic [PosBits-1:0] resume_pos_reg;
    logic [PosBits-1:0] resume_pos_next;
    logic               accept;
    logic [StepBits-1:0] threshold;
    logic [PosBits:0]   ref_end;

    assign in_ready  = !queue_full;
    assign accept    = in_valid && in_ready;
    assign threshold = 4'd1 + {1'b0, ref_bytes} + {1'b0, len_bytes};
    assign ref_end   = {1'b0, ref_target} + {1'b0, ref_length};

    always_comb
    begin
        text_pos_next   = text_pos_reg;
        resume_pos_next = resume_pos_reg;
        push            = 1'b0;
        cmd.kind        = CMD_TEXT;
        cmd.text_byte   = text_byte;
        cmd.val_a       = ref_source;
        cmd.val_b       = ref_length;
        case (opcode)
            OP_TEXT:
            begin
                push = accept && (text_pos_reg >= resume_pos_reg);
                if (accept && (text_pos_reg != {PosBits{1'b1}}))
                begin
                    text_pos_next = text_pos_reg + 1'b1;
                end
            end
            OP_REF:
            begin
                cmd.kind = CMD_REF;
                // drop references too short to pay for their token
                if (accept && (ref_length > {{(FieldBits-StepBits){1'b0}}, threshold}))
                begin
                    push            = 1'b1;
                    resume_pos_next = ref_end[PosBits] ? {PosBits{1'b1}}
                                                       : ref_end[PosBits-1:0];
                end
            end
            OP_START:
            begin
                cmd.kind  = CMD_HEADER;
                cmd.val_a = total_length;
                push      = accept;
                if (accept)
                begin
                    text_pos_next   = '0;
                    resume_pos_next = '0;
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_pos_reg   <= '0;
            resume_pos_reg <= '0;
        end
        else
        begin
            text_pos_reg   <= text_pos_next;
            resume_pos_reg <= resume_pos_next;
        end
    end

endmodule

### rtl/lzrts_queue.sv
// Short command queue between front end and serializer.
// Register-based FIFO of cmd_t entries with a look-ahead head. Uses lzrts_pkg.
`timescale 1ns / 1ps
module lzrts_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lzrts_pkg::cmd_t push_cmd,
    input  logic            pop,
    output lzrts_pkg::cmd_t head,
    output logic            empty,
    output logic            full
);
    import lzrts_pkg::*;

    cmd_t                    mem_reg [QueueDepth];
    logic [QueuePtrBits-1:0] wr_ptr_reg;
    logic [QueuePtrBits-1:0] wr_ptr_next;
    logic [QueuePtrBits-1:0] rd_ptr_reg;
    logic [QueuePtrBits-1:0] rd_ptr_next;
    logic [QueuePtrBits:0]   count_reg;
    logic [QueuePtrBits:0]   count_next;
    logic                    do_push;
    logic                    do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == QueueDepth[QueuePtrBits:0]);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/lzrts_back.sv
// Serializer: walks the queue head into a registered output stage with
// last marking, one byte per cycle unless stalled. Uses lzrts_pkg.
`timescale 1ns / 1ps
module lzrts_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lzrts_pkg::cmd_t                 head,
    input  logic                            empty,
    output logic                            pop,
    input  logic [lzrts_pkg::WidthBits-1:0] ref_bytes,
    input  logic [lzrts_pkg::WidthBits-1:0] len_bytes,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      out_byte,
    output logic                            out_last
);
    import lzrts_pkg::*;

    logic [StepBits-1:0] step_reg;
    logic [StepBits-1:0] step_next;
    logic                valid_reg;
    logic                valid_next;
    logic [7:0]          byte_reg;
    logic [7:0]          byte_next;
    logic                last_reg;
    logic                last_next;
    logic                load;
    logic [StepBits-1:0] last_step;
    logic [StepBits-1:0] src_idx;
    logic [StepBits-1:0] len_idx;
    logic                at_last;
    logic [7:0]          cur_byte;

    function automatic logic [7:0] pick_byte(input logic [FieldBits-1:0] v,
                                             input logic [1:0] idx);
        pick_byte = v[idx*8 +: 8];
    endfunction

    assign load    = !valid_reg || out_ready;
    assign src_idx = {1'b0, ref_bytes} - step_reg;
    assign len_idx = {1'b0, ref_bytes} + {1'b0, len_bytes} - step_reg;
    assign at_last = (step_reg == last_step);

    always_comb
    begin
        case (head.kind)
            CMD_TEXT:
            begin
                last_step = '0;
                cur_byte  = head.text_byte;
            end
            CMD_HEADER:
            begin
                last_step = HeaderLastStep;
                if (step_reg == HeaderLastStep)
                begin
                    cur_byte = {1'b0, ref_bytes, 1'b0, len_bytes};
                end
                else if (step_reg[2])
                begin
                    // low half of the 8-byte length, MSB first
                    cur_byte = pick_byte(head.val_a, ~step_reg[1:0]);
                end
                else
                begin
                    cur_byte = 8'h00;
                end
            end
            CMD_REF:
            begin
                last_step = {1'b0, ref_bytes} + {1'b0, len_bytes};
                if (step_reg == '0)
                begin
                    cur_byte = Marker;
                end
                else if (step_reg <= {1'b0, ref_bytes})
                begin
                    cur_byte = pick_byte(head.val_a, src_idx[1:0]);
                end
                else
                begin
                    cur_byte = pick_byte(head.val_b, len_idx[1:0]);
                end
            end
            default:
            begin
                last_step = '0;
                cur_byte  = 8'h00;
            end
        endcase
    end

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                byte_next = cur_byte;
                last_next = at_last;
                if (at_last)
                begin
                    pop       = 1'b1;
                    step_next = '0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

endmodule

### tb/lzrts_stream_checker.sv
`timescale 1ns / 1ps
// Stream checker for the LZ reference token serializer: watches the request,
// output and register-write ports, predicts the encoded bytes and compares them.
// Depends on lzrts_pkg.
module lzrts_stream_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // text_byte, ref_source, ref_length, ref_target, total_length
    input  logic [lzrts_pkg::TdataBits-1:0] s_tdata,
    // opcode
    input  logic [1:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // out_byte
    input  logic [7:0]                      m_tdata,
    input  logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [lzrts_pkg::WidthBits-1:0] cfg_data,
    output int                              mismatches,
    output int                              outstanding,
    output int                              requests_seen,
    output int                              bytes_checked,
    output int                              headers_seen,
    output int                              refs_emitted,
    output int                              refs_dropped
);
    import lzrts_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } enc_beat_t;

    enc_beat_t expected_bytes[$];

    logic [PosBits-1:0]   text_pos   = '0;
    logic [PosBits-1:0]   resume_pos = '0;
    logic [WidthBits-1:0] src_width  = MaxWidth;
    logic [WidthBits-1:0] len_width  = MaxWidth;

    int mismatch_count = 0;
    int request_count  = 0;
    int beat_count     = 0;
    int header_count   = 0;
    int emit_count     = 0;
    int drop_count     = 0;

    function automatic logic [WidthBits-1:0] clamp_width(input logic [WidthBits-1:0] v);
        return (v > MaxWidth) ? MaxWidth : v;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        // keep the log short when the block is badly off
        if (mismatch_count < 50)
            $display("[%0t] mismatch on %s: expected %02h, got %02h", $time, what, want, got);
        mismatch_count++;
    endtask

    task automatic push_byte(input logic [7:0] value);
        expected_bytes.push_back('{data: value, last: 1'b0});
    endtask

    task automatic push_msb_first(input logic [31:0] value, input logic [WidthBits-1:0] count);
        for (int i = int'(count); i > 0; i--)
            push_byte(8'(value >> (8 * (i - 1))));
    endtask

    // Work out the bytes one request produces and advance the position state.
    task automatic encode_request(input logic [1:0] op,
                                  input logic [TdataBits-1:0] d);
        logic [7:0]  txt;
        logic [31:0] src;
        logic [31:0] len;
        logic [31:0] tgt;
        logic [31:0] total;
        logic [32:0] reach;
        int          threshold;
        int          size_before;
        enc_beat_t   beat;
        txt   = d[7:0];
        src   = d[39:8];
        len   = d[71:40];
        tgt   = d[103:72];
        total = d[135:104];
        size_before = expected_bytes.size();
        threshold = 1 + int'(src_width) + int'(len_width);
        case (op)
            OP_START:
            begin
                push_msb_first(32'd0, 3'd4);
                push_msb_first(total, 3'd4);
                push_byte({1'b0, src_width, 1'b0, len_width});
                text_pos   = '0;
                resume_pos = '0;
                header_count++;
            end
            OP_TEXT:
            begin
                if (text_pos >= resume_pos)
                    push_byte(txt);
                if (text_pos != '1)
                    text_pos = text_pos + 1'b1;
            end
            OP_REF:
            begin
                if (len <= 32'(threshold))
                    drop_count++;
                else
                begin
                    push_byte(Marker);
                    push_msb_first(src, src_width);
                    push_msb_first(len, len_width);
                    reach = {1'b0, tgt} + {1'b0, len};
                    resume_pos = reach[32] ? '1 : reach[31:0];
                    emit_count++;
                end
            end
            default:
            begin
            end
        endcase
        if (expected_bytes.size() > size_before)
        begin
            beat = expected_bytes.pop_back();
            beat.last = 1'b1;
            expected_bytes.push_back(beat);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        enc_beat_t want;
        if (!rst_n)
        begin
            expected_bytes.delete();
            text_pos   = '0;
            resume_pos = '0;
            src_width  = MaxWidth;
            len_width  = MaxWidth;
        end
        else
        begin
            // check output first so a same-edge request cannot mask a stray byte
            if (m_tvalid && m_tready)
            begin
                if (expected_bytes.size() == 0)
                    report_mismatch("out_byte with nothing expected", 8'h00, m_tdata);
                else
                begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.data)
                        report_mismatch("out_byte", want.data, m_tdata);
                    if (m_tlast !== want.last)
                        report_mismatch("last", 8'(want.last), 8'(m_tlast));
                    beat_count++;
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_REF_BYTES)
                    src_width = clamp_width(cfg_data);
                else
                    len_width = clamp_width(cfg_data);
            end
            if (s_tvalid && s_tready)
            begin
                encode_request(s_tuser, s_tdata);
                request_count++;
            end
        end
        mismatches    <= mismatch_count;
        outstanding   <= expected_bytes.size();
        requests_seen <= request_count;
        bytes_checked <= beat_count;
        headers_seen  <= header_count;
        refs_emitted  <= emit_count;
        refs_dropped  <= drop_count;
    end

endmodule

### tb/tb_lz_reference_token_serializer_core.sv
`timescale 1ns / 1ps
// Top of the LZ reference token serializer testbench: clock, reset, request
// stimulus, output back-pressure and verdict. Depends on lzrts_pkg, the core
// and lzrts_stream_checker.
module tb_lz_reference_token_serializer_core;
    import lzrts_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int DrainCycles = 64;
    localparam int DrainLimit  = 20000;
    localparam int HoldCycles  = 400;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TdataBits-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;
    logic                 m_tlast;
    logic                 cfg_we;
    logic                 cfg_index;
    logic [WidthBits-1:0] cfg_data;

    int mismatches;
    int outstanding;
    int requests_seen;
    int bytes_checked;
    int headers_seen;
    int refs_emitted;
    int refs_dropped;

    bit steady      = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_active = 1'b0;
    int eff_ref     = 4;
    int eff_len     = 4;
    int settings_run = 0;

    lz_reference_token_serializer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lzrts_stream_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .requests_seen (requests_seen),
        .bytes_checked (bytes_checked),
        .headers_seen  (headers_seen),
        .refs_emitted  (refs_emitted),
        .refs_dropped  (refs_dropped)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    function automatic int next_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Output side: random stalls, none in steady phases, a long hold on request.
    initial
    begin : sink
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_active)
                m_tready <= 1'b0;
            else if (steady)
                m_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = next_gap();
            end
        end
    end

    // Hold the output off long enough for the input queue to fill and stall.
    initial
    begin : pressure
        wait (hold_req);
        @(negedge clk);
        hold_active = 1'b1;
        repeat (HoldCycles) @(negedge clk);
        hold_active = 1'b0;
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] txt,
                             input logic [31:0] src, input logic [31:0] len,
                             input logic [31:0] tgt, input logic [31:0] total);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {total, tgt, len, src, txt};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        int spent;
        spent = 0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 && spent < DrainLimit)
        begin
            @(posedge clk);
            spent++;
        end
        // let requests that produce no bytes clear the queue
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic change_widths(input logic [WidthBits-1:0] rw,
                                 input logic [WidthBits-1:0] lw, input bit steady_mode);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_REF_BYTES;
        cfg_data  <= rw;
        @(posedge clk);
        cfg_index <= REG_LEN_BYTES;
        cfg_data  <= lw;
        @(posedge clk);
        cfg_we <= 1'b0;
        eff_ref = (rw > MaxWidth) ? 4 : int'(rw);
        eff_len = (lw > MaxWidth) ? 4 : int'(lw);
        settings_run++;
        @(negedge clk);
        steady = steady_mode;
        @(posedge clk);
    endtask

    // Mostly well-formed frames: header, text, sorted non-overlapping references.
    task automatic random_stream(input int count);
        int                 sent;
        int                 r;
        int                 thr;
        logic [1:0]         op;
        logic [31:0]        len;
        logic [31:0]        tgt;
        longint unsigned    pos;
        longint unsigned    resume;
        thr = 1 + eff_ref + eff_len;
        send_item(OP_START, 8'($urandom), $urandom, $urandom, $urandom, $urandom);
        pos = 0;
        resume = 0;
        sent = 1;
        while (sent < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                op  = 2'($urandom_range(0, 3));
                len = $urandom;
                tgt = $urandom;
                send_item(op, 8'($urandom), $urandom, len, tgt, $urandom);
                if (op == OP_START)
                begin
                    pos = 0;
                    resume = 0;
                end
                else if (op == OP_TEXT)
                    pos++;
                else if (op == OP_REF && len > 32'(thr))
                    resume = longint'(tgt) + longint'(len);
            end
            else if (r < 10 || resume > pos + 64)
            begin
                send_item(OP_START, 8'($urandom), $urandom, $urandom, $urandom, $urandom);
                pos = 0;
                resume = 0;
            end
            else if (r < 32 && pos >= resume)
            begin
                if (r < 29)
                    len = $urandom_range((thr > 2) ? thr - 2 : 0, thr + 6);
                else
                    len = $urandom_range(0, 48);
                send_item(OP_REF, 8'($urandom), $urandom_range(0, 32'(pos)), len,
                          32'(pos), $urandom);
                if (len > 32'(thr))
                    resume = pos + len;
            end
            else
            begin
                send_item(OP_TEXT, 8'($urandom), $urandom, $urandom, $urandom, $urandom);
                pos++;
            end
            sent++;
        end
    endtask

    // Default widths of 4: threshold 9, the first references land at text position 4.
    task automatic directed_checks();
        send_item(OP_START, 8'h00, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
        send_item(OP_TEXT, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(OP_TEXT, 8'hFF, '1, '1, '1, '1);
        // raw marker byte passes through unescaped
        send_item(OP_TEXT, Marker, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(OP_TEXT, 8'h5A, 32'h0, 32'h0, 32'h0, 32'h0);
        // length right at the threshold: dropped
        send_item(OP_REF, 8'h00, 32'h0, 32'd9, 32'd4, 32'h0);
        send_item(OP_UNUSED, 8'hFF, '1, '1, '1, '1);
        send_item(OP_REF, 8'h00, 32'hFFFF_FFFF, 32'd10, 32'd4, 32'h0);
        repeat (3)
            send_item(OP_TEXT, 8'($urandom), 32'h0, 32'h0, 32'h0, 32'h0);
        // target plus length overflows: resume saturates
        send_item(OP_REF, 8'h00, 32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_item(OP_TEXT, 8'hC3, 32'h0, 32'h0, 32'h0, 32'h0);
        // resume moves back from saturation, still ahead of the current position
        send_item(OP_REF, 8'h00, 32'h1, 32'd10, 32'd0, 32'h0);
        repeat (4)
            send_item(OP_TEXT, 8'($urandom), 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(OP_START, 8'hFF, '1, '1, '1, 32'h0);
    endtask

    initial
    begin : stimulus
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_TEXT;
        cfg_we    = 1'b0;
        cfg_index = REG_REF_BYTES;
        cfg_data  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_checks();

        // zero widths: threshold 1, an emitted reference is the marker alone
        change_widths(3'd0, 3'd0, 1'b0);
        send_item(OP_START, 8'h00, 32'h0, 32'h0, 32'h0, 32'h0000_00A5);
        send_item(OP_REF, 8'h00, 32'h0, 32'd1, 32'd0, 32'h0);
        send_item(OP_REF, 8'h00, '1, 32'd2, 32'd0, 32'h0);
        send_item(OP_TEXT, 8'h11, 32'h0, 32'h0, 32'h0, 32'h0);
        random_stream(45);

        // out-of-range values clamp to 4; back-to-back requests under a long hold
        change_widths(3'd7, 3'd6, 1'b1);
        hold_req = 1'b1;
        random_stream(60);

        change_widths(3'd1, 3'd4, 1'b0);
        random_stream(45);
        change_widths(3'd4, 3'd0, 1'b0);
        random_stream(45);
        change_widths(3'd0, 3'd4, 1'b0);
        random_stream(45);
        change_widths(3'd2, 3'd3, 1'b1);
        random_stream(45);
        change_widths(3'd5, 3'd1, 1'b0);
        random_stream(45);
        change_widths(3'd3, 3'd3, 1'b0);
        random_stream(45);
        change_widths(3'd4, 3'd4, 1'b0);
        random_stream(40);

        wait_idle();
        $display(
            "Covered %0d requests, %0d width settings, %0d headers, %0d refs emitted, %0d dropped.",
            requests_seen, settings_run + 1, headers_seen, refs_emitted, refs_dropped);
        $display("Checked %0d output bytes, %0d mismatches, %0d bytes never produced.",
                 bytes_checked, mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
